[sv/htfd_pkg.sv]
// htfd_pkg: shared types, constants and the crc-8 helper for the frame decoder
// used by htfd_conv and humidity_temp_frame_decoder_unit; no dependencies
package htfd_pkg;

    // frame kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_HUM         = 2'd0,
        KIND_TEMP        = 2'd1,
        KIND_TEMP_NO_CRC = 2'd2
    } t_kind;

    // crc-8, polynomial x^8+x^5+x^4+1, init 0, msb first
    localparam logic [7:0] CRC_POLY = 8'h31;

    // fixed point conversion constants (hundredths)
    localparam logic [14:0]        RH_SCALE  = 15'd12500;
    localparam logic [14:0]        T_SCALE   = 15'd17572;
    localparam logic signed [15:0] RH_OFFSET = 16'sd600;
    localparam logic signed [15:0] RH_MAX    = 16'sd10000;
    localparam logic signed [15:0] T_OFFSET  = 16'sd4685;

    // one decoded result
    typedef struct packed {
        logic signed [14:0] value_centi;
        logic               status;
    } t_result;

    // shift one byte through the crc register
    function automatic logic [7:0] htfd_crc_byte(input logic [7:0] crc_in,
                                                 input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int j = 0; j < 8; j++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[sv/humidity_temp_frame_decoder_unit.sv]
// humidity_temp_frame_decoder_unit: stream top level, input register, decode, result register
// depends on htfd_pkg and htfd_conv
//
//  channel   dir  tdata                                       tuser
//  s_axis    in   [7:0] msb_byte [15:8] lsb_byte [23:16] chk  [1:0] req_type
//  m_axis    out  [14:0] value_centi (signed) [15] zero       [0] status
//
// a frame goes from accepted input beat to result beat through the input register,
// then through the crc and multiply into the result register.
// throughput is one frame per cycle; both registers advance whenever the result
// register is empty or its beat is taken.
// synchronous active-low reset empties both stages; payload registers are not reset.
// a stall on m_axis holds the result, then the input register, then drops tready.
module humidity_temp_frame_decoder_unit
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // msb_byte, lsb_byte, check_byte
    input  logic [1:0]  i_s_axis_tuser,   // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // value_centi, zero pad
    output logic [0:0]  o_m_axis_tuser    // status
);

    logic        r_in_valid;
    logic [1:0]  r_in_kind;
    logic [23:0] r_in_data;
    logic        r_out_valid;
    t_result     r_out;
    logic        out_load;
    logic        in_load;
    t_result     result;

    // stage advance
    assign out_load        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || out_load;
    assign in_load         = o_s_axis_tready && i_s_axis_tvalid;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_kind <= i_s_axis_tuser;
            r_in_data <= i_s_axis_tdata;
        end
    end

    htfd_conv u_conv (
        .i_kind       (r_in_kind),
        .i_msb_byte   (r_in_data[7:0]),
        .i_lsb_byte   (r_in_data[15:8]),
        .i_check_byte (r_in_data[23:16]),
        .o_result     (result)
    );

    // result capture
    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.value_centi};
    assign o_m_axis_tuser  = r_out.status;

endmodule

[sv/htfd_conv.sv]
// htfd_conv: combinational crc check and code-to-hundredths conversion of one frame
// depends on htfd_pkg
module htfd_conv
    import htfd_pkg::*;
(
    input  logic [1:0] i_kind,
    input  logic [7:0] i_msb_byte,
    input  logic [7:0] i_lsb_byte,
    input  logic [7:0] i_check_byte,
    output t_result    o_result
);

    logic [7:0]         crc_calc;
    logic               crc_ok;
    logic [15:0]        code;
    logic [14:0]        scale;
    logic [30:0]        prod;
    logic [14:0]        scaled;
    logic signed [15:0] offset;
    logic signed [15:0] diff;
    logic signed [15:0] hum_clamped;

    // crc over high byte then low byte
    assign crc_calc = htfd_crc_byte(htfd_crc_byte(8'h00, i_msb_byte), i_lsb_byte);
    assign crc_ok   = (crc_calc == i_check_byte);

    // one shared constant multiply, scale picked by kind
    assign code   = {i_msb_byte, i_lsb_byte};
    assign scale  = (i_kind == KIND_HUM) ? RH_SCALE : T_SCALE;
    assign prod   = {15'd0, code} * {16'd0, scale};
    assign scaled = prod[30:16];
    assign offset = (i_kind == KIND_HUM) ? RH_OFFSET : T_OFFSET;
    assign diff   = $signed({1'b0, scaled}) - offset;

    // humidity clamp to 0..10000
    always_comb begin
        if (diff < 16'sd0) begin
            hum_clamped = 16'sd0;
        end else if (diff > RH_MAX) begin
            hum_clamped = RH_MAX;
        end else begin
            hum_clamped = diff;
        end
    end

    // result select by kind; bad check or unused kind gives zero and status set
    always_comb begin
        o_result = '0;
        unique case (i_kind)
            KIND_HUM: begin
                if (crc_ok) begin
                    o_result.value_centi = hum_clamped[14:0];
                end else begin
                    o_result.status = 1'b1;
                end
            end
            KIND_TEMP: begin
                if (crc_ok) begin
                    o_result.value_centi = diff[14:0];
                end else begin
                    o_result.status = 1'b1;
                end
            end
            KIND_TEMP_NO_CRC: begin
                o_result.value_centi = diff[14:0];
            end
            default: begin
                o_result.status = 1'b1;
            end
        endcase
    end

endmodule

[sv/htfd_checker.sv]
// htfd_checker: port-level assertions for the frame decoder, bound to the top level
// depends on humidity_temp_frame_decoder_unit ports only
module htfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [23:0] i_s_axis_tdata,
    input logic [1:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // failed frames carry a zero value
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == 16'd0)
        else $error("nonzero value with error status");

    // good values stay in the converted range, pad bit zero
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[15] &&
            ($signed(o_m_axis_tdata[14:0]) >= -15'sd4685) &&
            ($signed(o_m_axis_tdata[14:0]) <= 15'sd12886))
        else $error("value out of range");

    // an empty pipeline takes an input beat
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind humidity_temp_frame_decoder_unit htfd_checker u_htfd_checker (.*);

[dv/htfd_checker.sv]
// htfd_scoreboard: watches both stream channels of the frame decoder, predicts each result
// from the accepted frame and compares it with the result beat; depends on htfd_pkg
module htfd_scoreboard
    import htfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,    // msb_byte, lsb_byte, check_byte
    input  logic [1:0]  i_s_tuser,    // req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,    // value_centi, zero pad
    input  logic [0:0]  i_m_tuser,    // status
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    t_result decoded_q[$];

    // bitwise crc-8 over the 16-bit code, high byte first
    function automatic logic [7:0] code_crc(input logic [15:0] code);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 15; i >= 0; i--) begin
            if (r[7] ^ code[i]) begin
                r = {r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

    // temperature in hundredths of a degree, floor of the scaled code
    function automatic int temp_centi(input logic [15:0] code);
        int unsigned prod;
        prod = 32'(T_SCALE) * 32'(code);
        return int'(prod >> 16) - int'(T_OFFSET);
    endfunction

    // expected result for one reply frame
    function automatic t_result decode_frame(input logic [1:0] kind, input logic [7:0] msb,
                                             input logic [7:0] lsb, input logic [7:0] chk);
        logic [15:0] code;
        int unsigned prod;
        int          centi;
        t_result     r;
        code     = {msb, lsb};
        centi    = 0;
        r.status = 1'b0;
        case (kind)
            KIND_HUM, KIND_TEMP: begin
                if (code_crc(code) != chk) begin
                    r.status = 1'b1;
                end else if (kind == KIND_HUM) begin
                    prod  = 32'(RH_SCALE) * 32'(code);
                    centi = int'(prod >> 16) - int'(RH_OFFSET);
                    if (centi < 0) centi = 0;
                    if (centi > int'(RH_MAX)) centi = int'(RH_MAX);
                end else begin
                    centi = temp_centi(code);
                end
            end
            KIND_TEMP_NO_CRC: begin
                centi = temp_centi(code);
            end
            // unused kind is an invalid request
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.value_centi = centi[14:0];
        return r;
    endfunction

    // sample at the falling edge: handshakes are stable until the next rising edge
    always @(negedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                decoded_q.push_back(decode_frame(i_s_tuser, i_s_tdata[7:0],
                                                 i_s_tdata[15:8], i_s_tdata[23:16]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value_centi = i_m_tdata[14:0];
                got.status      = i_m_tuser[0];
                if (decoded_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("mismatch: result beat with nothing pending, %s %0d status %0b",
                                 "value", got.value_centi, got.status);
                    end
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    o_checked++;
                    if (got.value_centi !== want.value_centi || got.status !== want.status) begin
                        if (o_fail_count < 10) begin
                            $display("mismatch: result %0d value %0d/%0d status %0b/%0b (exp/act)",
                                     o_checked, want.value_centi, got.value_centi,
                                     want.status, got.status);
                        end
                        o_fail_count++;
                    end
                end
            end
            o_pending = decoded_q.size();
        end
    end

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

endmodule

[dv/tb_top.sv]
// tb_top: stimulus and verdict for humidity_temp_frame_decoder_unit
// depends on htfd_pkg, the decoder rtl and htfd_scoreboard
module tb_top
    import htfd_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT  = 2000;
    localparam int         CHUNK_ITEMS = 167;

    logic        i_clk;
    logic        i_rst_n;
    logic        tx_valid;
    logic [23:0] tx_data;
    logic [1:0]  tx_kind;
    logic        rx_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    int fail_count;
    int pending;
    int checked;
    int tx_idle_pct;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;
    int kind_count[4];
    int bad_check_frames;

    humidity_temp_frame_decoder_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tx_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (tx_data),
        .i_s_axis_tuser  (tx_kind),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    htfd_scoreboard checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (tx_valid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (tx_data),
        .i_s_tuser    (tx_kind),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (rx_ready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        rx_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // watchdog on cycles with no beat on either channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((tx_valid && o_s_axis_tready) || (o_m_axis_tvalid && rx_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results pending",
                         IDLE_LIMIT, pending);
                $display("** humidity_temp_frame_decoder_unit: FAILED **");
                $finish;
            end
        end
    end

    // check byte generator for well-formed frames
    function automatic logic [7:0] good_check(input logic [15:0] code);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 15; i >= 0; i--) begin
            r = (r[7] ^ code[i]) ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // one input beat with optional leading gap; returns at the accepting edge
    task automatic send_frame(input logic [1:0] kind, input logic [15:0] code,
                              input logic [7:0] chk);
        logic taken;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge i_clk);
        end
        tx_valid <= 1'b1;
        tx_data  <= {chk, code[7:0], code[15:8]};
        tx_kind  <= kind;
        do begin
            @(negedge i_clk);
            taken = o_s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        kind_count[kind]++;
        if (kind != KIND_TEMP_NO_CRC && chk != good_check(code)) bad_check_frames++;
    endtask

    task automatic send_good(input logic [1:0] kind, input logic [15:0] code);
        send_frame(kind, code, good_check(code));
    endtask

    // mostly well-formed frames, some corrupted check bytes and unused kinds
    task automatic send_random_frame();
        int          pick;
        logic [1:0]  kind;
        logic [15:0] code;
        logic [7:0]  chk;
        pick = $urandom_range(99);
        kind = (pick < 40) ? KIND_HUM : (pick < 75) ? KIND_TEMP :
               (pick < 92) ? KIND_TEMP_NO_CRC : KIND_UNUSED;
        code = 16'($urandom);
        chk  = ($urandom_range(99) < 80) ? good_check(code) : 8'($urandom);
        send_frame(kind, code, chk);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        tx_valid         = 1'b0;
        tx_data          = '0;
        tx_kind          = '0;
        tx_idle_pct      = 0;
        bad_check_frames = 0;
        foreach (kind_count[k]) kind_count[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: code extremes, humidity clamp edges, each kind, bad check bytes
        send_good(KIND_HUM, 16'h0000);
        send_good(KIND_HUM, 16'd3145);
        send_good(KIND_HUM, 16'd3146);
        send_good(KIND_HUM, 16'd3147);
        send_good(KIND_HUM, 16'd55574);
        send_good(KIND_HUM, 16'd55575);
        send_good(KIND_HUM, 16'hFFFF);
        send_good(KIND_HUM, 16'hBEEF);
        send_good(KIND_TEMP, 16'h0000);
        send_good(KIND_TEMP, 16'hFFFF);
        send_good(KIND_TEMP, 16'h8000);
        send_good(KIND_TEMP, 16'h7FFF);
        send_frame(KIND_TEMP_NO_CRC, 16'h0000, 8'hFF);
        send_frame(KIND_TEMP_NO_CRC, 16'hFFFF, 8'h00);
        send_frame(KIND_TEMP_NO_CRC, 16'h6666, 8'hA5);
        send_frame(KIND_HUM, 16'h1234, good_check(16'h1234) ^ 8'h01);
        send_frame(KIND_TEMP, 16'hFFFF, good_check(16'hFFFF) ^ 8'h80);
        send_frame(KIND_HUM, 16'h0000, 8'hFF);
        send_good(KIND_UNUSED, 16'h5A5A);
        send_frame(KIND_UNUSED, 16'hFFFF, 8'h00);

        // random: cycle through the idle modes, draining between chunks
        for (int chunk = 0; chunk < 8; chunk++) begin
            tx_valid <= 1'b0;
            while (pending != 0) @(posedge i_clk);
            case (chunk % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 55; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 55; end
                default: begin tx_idle_pct = 15; rx_stall_pct <= 15; end
            endcase
            @(posedge i_clk);
            repeat (CHUNK_ITEMS) send_random_frame();
        end

        // drain
        tx_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("frames: %0d humidity, %0d temperature, %0d temperature without check, %s",
                 kind_count[0], kind_count[1], kind_count[2],
                 $sformatf("%0d unused kind", kind_count[3]));
        $display("%0d frames carried a corrupted check byte; %0d results compared",
                 bad_check_frames, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("** humidity_temp_frame_decoder_unit: PASSED **");
        end else begin
            $display("** humidity_temp_frame_decoder_unit: FAILED **");
        end
        $finish;
    end

endmodule
